// ===== hdl/sdsr_pkg.sv =====
package sdsr_pkg;

	localparam int unsigned SECTOR_BYTES = 512;
	localparam int unsigned SECTOR_AW    = $clog2(SECTOR_BYTES);

	// request opcodes carried in tuser
	localparam logic [1:0] OP_INIT    = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_RESPONSE_TRIES   = 2'd0;
	localparam logic [1:0] CFG_IDLE_RETRY_LIMIT = 2'd1;
	localparam logic [1:0] CFG_TOKEN_WAIT_LIMIT = 2'd2;
	localparam logic [1:0] CFG_PREAMBLE_BYTES   = 2'd3;

	// command bytes, bit 7 marks an app command preceded by cmd55
	localparam logic [7:0] C_GO_IDLE  = 8'h40;
	localparam logic [7:0] C_IF_COND  = 8'h48;
	localparam logic [7:0] C_OP_MMC   = 8'h41;
	localparam logic [7:0] C_OP_SD    = 8'hE9;
	localparam logic [7:0] C_APP      = 8'h77;
	localparam logic [7:0] C_OCR      = 8'h7A;
	localparam logic [7:0] C_BLOCKLEN = 8'h50;
	localparam logic [7:0] C_READ     = 8'h51;

	localparam logic [7:0] CRC_GO_IDLE = 8'h95;
	localparam logic [7:0] CRC_IF_COND = 8'h87;
	localparam logic [7:0] CRC_DUMMY   = 8'h01;
	localparam logic [7:0] BYTE_IDLE   = 8'hFF;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [7:0] R7_PATTERN  = 8'hAA;
	localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
	localparam logic [31:0] HCS_ARG     = 32'h4000_0000;

	// result tdata bit positions
	localparam int unsigned O_XFER   = 0;
	localparam int unsigned O_MOSI   = 1;
	localparam int unsigned O_CS     = 9;
	localparam int unsigned O_DV     = 10;
	localparam int unsigned O_DATA   = 11;
	localparam int unsigned O_DONE   = 19;
	localparam int unsigned O_STATUS = 20;
	localparam int unsigned O_KIND   = 21;

	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		at_least_one = (v == 16'd0) ? 16'd1 : v;
	endfunction

	// one byte of a six-byte command frame preceded by two idle bytes
	function automatic logic [7:0] frame_byte(input logic [7:0] wc, input logic [31:0] arg,
	                                          input logic [2:0] idx);
		case (idx)
			3'd0, 3'd1: frame_byte = BYTE_IDLE;
			3'd2: frame_byte = wc;
			3'd3: frame_byte = arg[31:24];
			3'd4: frame_byte = arg[23:16];
			3'd5: frame_byte = arg[15:8];
			3'd6: frame_byte = arg[7:0];
			default: frame_byte = (wc == C_GO_IDLE) ? CRC_GO_IDLE :
			                      ((wc == C_IF_COND) ? CRC_IF_COND : CRC_DUMMY);
		endcase
	endfunction

endpackage

// ===== hdl/sdsr_ram.sv =====
module sdsr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/sd_spi_init_and_sector_read_top.sv =====
// SPI-mode SD/MMC sequencer. Every request (tuser op: init, read, advance) gives exactly one
// result that tells the SPI shifter which byte to exchange next and with what chip select, and
// carries any delivered sector byte, the done/status flags and the card type. Init runs the
// deselected 0xFF preamble, cmd0, cmd8 with the r7 echo check, acmd41/cmd1 retries, the ocr read
// and cmd16 for SDv1/MMC. A read sends cmd17, waits for the 0xFE token and takes 512 bytes plus
// two crc bytes; a whole-sector read streams to the host, any other read fills a one-sector
// cache from which the asked-for bytes are delivered, one per advance. Requests are taken one
// per clock while the output is not stalled: the sequencer step is done on the accepting edge
// and the result sits in an output register, so the next request is taken in the same cycle the
// pending result is taken. The sector cache read is a registered ram port aligned with that
// register. The cache needs no clearing after reset, it is only read once filled.
module sd_spi_init_and_sector_read_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sector[31:0], offset[40:32], count[50:41], card_byte[58:51], zeros above
	input  logic [63:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// xfer_valid[0], mosi_byte[8:1], cs_active[9], data_valid[10], data_byte[18:11],
	// done_res[19], status[20], card_kind[24:21], zeros above
	output logic [31:0] m_tdata
);
	import sdsr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PRE, ST_CMD0, ST_CMD8, ST_R7, ST_HCWAIT, ST_OCR, ST_OCRDATA, ST_PROBE,
		ST_V1WAIT, ST_CMD16, ST_CMD17, ST_TOKEN, ST_DATA, ST_CRC, ST_DELIVER, ST_FINISH
	} state_t;

	// configuration
	logic [7:0]  tries_q;
	logic [15:0] idle_lim_q, token_lim_q;
	logic [9:0]  pre_q;

	// sequencer state
	state_t      seq_q, n_seq;
	logic [3:0]  type_q, n_type;
	logic [31:0] cached_q, n_cached;
	logic        cv_q, n_cv;
	logic [2:0]  fi_q, n_fi;
	logic [7:0]  cmd_q, n_cmd;
	logic [31:0] arg_q, n_arg;
	logic [31:0] resp_q, n_resp;
	logic [15:0] retry_q, n_retry;
	logic [9:0]  bc_q, n_bc;
	logic [31:0] rsec_q, n_rsec;
	logic [8:0]  roff_q, n_roff;
	logic [9:0]  rcnt_q, n_rcnt;
	logic        direct_q, n_direct;
	logic        app_q, n_app;
	logic        inr_q, n_inr;
	logic        ferr_q, n_ferr;

	// result register
	logic        out_valid_q;
	logic        xv_q, cs_q, dv_q, done_q, st_q, dv_ram_q;
	logic [7:0]  mosi_q, db_q;
	logic [3:0]  kind_q;

	logic        acc;
	logic [1:0]  op;
	logic [31:0] in_sec;
	logic [8:0]  in_off;
	logic [9:0]  in_cnt, clip_cnt, room;
	logic [7:0]  b;

	// pending command start, applied after the request is handled
	logic        st_go;
	state_t      st_seq;
	logic [7:0]  st_cmd;
	logic [31:0] st_arg;

	logic        o_xv, o_cs, o_dv, o_done, o_st, o_dv_ram;
	logic [7:0]  o_mosi, o_db;
	logic [10:0] bc_inc;
	logic [15:0] retry_dec;
	logic [9:0]  bc_dec;
	logic [7:0]  wc;

	logic                 ram_we, ram_re;
	logic [SECTOR_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]           ram_rdata;

	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign op       = s_tuser;
	assign in_sec   = s_tdata[31:0];
	assign in_off   = s_tdata[40:32];
	assign in_cnt   = s_tdata[50:41];
	assign b        = s_tdata[58:51];
	assign room     = 10'(SECTOR_BYTES) - {1'b0, in_off};
	assign clip_cnt = (in_cnt > room) ? room : in_cnt;
	assign bc_inc   = {1'b0, bc_q} + 11'd1;
	assign retry_dec = retry_q - 16'd1;
	assign bc_dec   = bc_q - 10'd1;

	always_comb begin
		n_seq = seq_q;  n_type = type_q; n_cached = cached_q; n_cv = cv_q; n_fi = fi_q;
		n_cmd = cmd_q;  n_arg = arg_q;   n_resp = resp_q;     n_retry = retry_q;
		n_bc = bc_q;    n_rsec = rsec_q; n_roff = roff_q;     n_rcnt = rcnt_q;
		n_direct = direct_q; n_app = app_q; n_inr = inr_q;    n_ferr = ferr_q;
		st_go = 1'b0; st_seq = ST_IDLE; st_cmd = '0; st_arg = '0;
		o_xv = 1'b0; o_cs = 1'b0; o_dv = 1'b0; o_done = 1'b0; o_st = 1'b0; o_dv_ram = 1'b0;
		o_mosi = '0; o_db = '0;
		ram_we = 1'b0; ram_waddr = bc_q[SECTOR_AW-1:0]; ram_re = 1'b0; ram_raddr = '0;
		wc = '0;

		case (op)
			OP_INIT: begin
				n_type = '0; n_cached = '1; n_cv = 1'b0; n_inr = 1'b0; n_app = 1'b0;
				n_bc = '0;
				if (pre_q == 10'd0) begin
					st_go = 1'b1; st_seq = ST_CMD0; st_cmd = C_GO_IDLE;
				end else begin
					n_seq = ST_PRE;
				end
			end
			OP_READ: begin
				n_rsec = in_sec; n_roff = in_off; n_rcnt = clip_cnt;
				n_direct = (in_off == 9'd0) && (clip_cnt == 10'(SECTOR_BYTES));
				n_inr = 1'b0; n_app = 1'b0;
				if (cv_q && cached_q == in_sec) begin
					// cache hit
					n_bc = '0;
					if (clip_cnt == 10'd0) begin
						n_seq = ST_FINISH; n_ferr = 1'b0;
					end else begin
						n_seq = ST_DELIVER;
					end
				end else begin
					if (seq_q == ST_DATA || seq_q == ST_CRC) n_cv = 1'b0;
					st_go = 1'b1; st_seq = ST_CMD17; st_cmd = C_READ;
					st_arg = type_q[3] ? in_sec : {in_sec[31-SECTOR_AW:0], {SECTOR_AW{1'b0}}};
				end
			end
			OP_ADVANCE: begin
				if (seq_q inside {ST_CMD0, ST_CMD8, ST_HCWAIT, ST_OCR, ST_PROBE, ST_V1WAIT,
				                  ST_CMD16, ST_CMD17}) begin
					if (!inr_q) begin
						if (fi_q == 3'd7) begin
							n_fi = '0; n_inr = 1'b1;
							n_bc = 10'(at_least_one({8'd0, tries_q}));
						end else begin
							n_fi = fi_q + 3'd1;
						end
					end else if (b[7] && bc_dec != 10'd0) begin
						n_bc = bc_dec;
					end else begin
						if (b[7]) n_bc = bc_dec;
						n_inr = 1'b0;
						if (app_q) begin
							n_app = 1'b0; n_fi = '0;
						end
						if (!app_q || b > 8'd1) begin
							case (seq_q)
								ST_CMD0: begin
									if (b != 8'd1) begin
										n_seq = ST_FINISH; n_ferr = 1'b1;
									end else begin
										st_go = 1'b1; st_seq = ST_CMD8; st_cmd = C_IF_COND;
										st_arg = IF_COND_ARG;
									end
								end
								ST_CMD8: begin
									if (b == 8'd1) begin
										n_seq = ST_R7; n_bc = '0; n_resp = '0;
									end else begin
										st_go = 1'b1; st_seq = ST_PROBE; st_cmd = C_OP_SD;
									end
								end
								ST_HCWAIT, ST_V1WAIT: begin
									if (b == 8'd0) begin
										st_go = 1'b1;
										if (seq_q == ST_HCWAIT) begin
											st_seq = ST_OCR; st_cmd = C_OCR;
										end else begin
											st_seq = ST_CMD16; st_cmd = C_BLOCKLEN;
											st_arg = 32'(SECTOR_BYTES);
										end
									end else begin
										n_retry = retry_dec;
										if (retry_dec == 16'd0) begin
											if (seq_q == ST_V1WAIT) n_type = '0;
											n_seq = ST_FINISH; n_ferr = 1'b1;
										end else begin
											st_go = 1'b1; st_seq = seq_q; st_cmd = cmd_q;
											st_arg = arg_q;
										end
									end
								end
								ST_OCR: begin
									if (b != 8'd0) begin
										n_seq = ST_FINISH; n_ferr = 1'b1;
									end else begin
										n_seq = ST_OCRDATA; n_bc = '0; n_resp = '0;
									end
								end
								ST_PROBE: begin
									n_type = (b <= 8'd1) ? 4'h2 : 4'h1;
									n_retry = at_least_one(idle_lim_q);
									st_go = 1'b1; st_seq = ST_V1WAIT;
									st_cmd = (b <= 8'd1) ? C_OP_SD : C_OP_MMC;
								end
								ST_CMD16: begin
									if (b != 8'd0) n_type = '0;
									n_seq = ST_FINISH; n_ferr = (b != 8'd0);
								end
								ST_CMD17: begin
									if (b != 8'd0) begin
										n_seq = ST_FINISH; n_ferr = 1'b1;
									end else begin
										n_retry = at_least_one(token_lim_q);
										n_seq = ST_TOKEN;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end else begin
					case (seq_q)
						ST_PRE: begin
							n_bc = bc_inc[9:0];
							if (bc_inc >= {1'b0, pre_q}) begin
								st_go = 1'b1; st_seq = ST_CMD0; st_cmd = C_GO_IDLE;
							end
						end
						ST_R7, ST_OCRDATA: begin
							n_resp = {resp_q[23:0], b};
							n_bc = bc_inc[9:0];
							if (bc_inc >= 11'd4) begin
								if (seq_q == ST_R7) begin
									if (n_resp[15:8] != 8'h01 || n_resp[7:0] != R7_PATTERN) begin
										n_seq = ST_FINISH; n_ferr = 1'b1;
									end else begin
										n_retry = at_least_one(idle_lim_q);
										st_go = 1'b1; st_seq = ST_HCWAIT; st_cmd = C_OP_SD;
										st_arg = HCS_ARG;
									end
								end else begin
									n_type = n_resp[30] ? 4'hC : 4'h4;
									n_seq = ST_FINISH; n_ferr = 1'b0;
								end
							end
						end
						ST_TOKEN: begin
							if (b == BYTE_IDLE) n_retry = retry_dec;
							if (b != BYTE_IDLE || retry_dec == 16'd0) begin
								if (b != TOKEN_START) begin
									n_seq = ST_FINISH; n_ferr = 1'b1;
								end else begin
									n_bc = '0;
									if (!direct_q) n_cv = 1'b0;
									n_seq = ST_DATA;
								end
							end
						end
						ST_DATA: begin
							if (direct_q) begin
								o_dv = 1'b1; o_db = b;
							end else begin
								ram_we = acc;
							end
							n_bc = bc_inc[9:0];
							if (bc_inc >= 11'(SECTOR_BYTES)) begin
								n_bc = '0; n_seq = ST_CRC;
							end
						end
						ST_CRC: begin
							n_bc = bc_inc[9:0];
							if (bc_inc >= 11'd2) begin
								if (direct_q) begin
									n_seq = ST_FINISH; n_ferr = 1'b0;
								end else begin
									n_cached = rsec_q; n_cv = 1'b1; n_bc = '0;
									if (rcnt_q == 10'd0) begin
										n_seq = ST_FINISH; n_ferr = 1'b0;
									end else begin
										n_seq = ST_DELIVER;
									end
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		if (st_go) begin
			n_seq = st_seq; n_cmd = st_cmd; n_arg = st_arg; n_app = st_cmd[7];
			n_inr = 1'b0; n_fi = '0;
		end

		// result for the state just reached
		if (op != OP_NONE) begin
			case (n_seq)
				ST_IDLE: begin
				end
				ST_DELIVER: begin
					o_dv = 1'b1; o_dv_ram = 1'b1;
					ram_re = acc;
					ram_raddr = n_roff + n_bc[SECTOR_AW-1:0];
					if (({1'b0, n_bc} + 11'd1) >= {1'b0, n_rcnt}) begin
						n_seq = ST_FINISH; n_ferr = 1'b0;
					end
					n_bc = n_bc + 10'd1;
				end
				ST_FINISH: begin
					o_xv = 1'b1; o_mosi = BYTE_IDLE; o_done = 1'b1; o_st = n_ferr;
					n_seq = ST_IDLE;
				end
				ST_PRE: begin
					o_xv = 1'b1; o_mosi = BYTE_IDLE;
				end
				default: begin
					o_xv = 1'b1; o_mosi = BYTE_IDLE; o_cs = 1'b1;
					if (n_seq inside {ST_CMD0, ST_CMD8, ST_HCWAIT, ST_OCR, ST_PROBE, ST_V1WAIT,
					                  ST_CMD16, ST_CMD17} && !n_inr) begin
						wc = n_app ? C_APP : {1'b0, n_cmd[6:0]};
						o_mosi = frame_byte(wc, n_app ? 32'd0 : n_arg, n_fi);
						o_cs = (n_fi != 3'd0);
					end
				end
			endcase
		end
	end

	sdsr_ram #(
		.WIDTH(8),
		.DEPTH(SECTOR_BYTES)
	) u_cache (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(b),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tries_q <= 8'd10; idle_lim_q <= 16'hFFFF; token_lim_q <= 16'hFFFF; pre_q <= 10'd522;
			seq_q <= ST_IDLE; type_q <= '0; cached_q <= '1; cv_q <= 1'b0; fi_q <= '0;
			cmd_q <= '0; arg_q <= '0; resp_q <= '0; retry_q <= '0; bc_q <= '0;
			rsec_q <= '0; roff_q <= '0; rcnt_q <= '0; direct_q <= 1'b0; app_q <= 1'b0;
			inr_q <= 1'b0; ferr_q <= 1'b0;
			out_valid_q <= 1'b0; dv_ram_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_RESPONSE_TRIES:   tries_q <= cfg_wdata[7:0];
					CFG_IDLE_RETRY_LIMIT: idle_lim_q <= cfg_wdata;
					CFG_TOKEN_WAIT_LIMIT: token_lim_q <= cfg_wdata;
					CFG_PREAMBLE_BYTES:   pre_q <= cfg_wdata[9:0];
					default: begin
					end
				endcase
			end
			if (acc) begin
				seq_q <= n_seq; type_q <= n_type; cached_q <= n_cached; cv_q <= n_cv;
				fi_q <= n_fi; cmd_q <= n_cmd; arg_q <= n_arg; resp_q <= n_resp;
				retry_q <= n_retry; bc_q <= n_bc; rsec_q <= n_rsec; roff_q <= n_roff;
				rcnt_q <= n_rcnt; direct_q <= n_direct; app_q <= n_app; inr_q <= n_inr;
				ferr_q <= n_ferr;
				out_valid_q <= 1'b1; dv_ram_q <= o_dv_ram;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			xv_q <= o_xv; mosi_q <= o_mosi; cs_q <= o_cs; dv_q <= o_dv; db_q <= o_db;
			done_q <= o_done; st_q <= o_st; kind_q <= n_type;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, kind_q, st_q, done_q, (dv_ram_q ? ram_rdata : db_q), dv_q, cs_q,
	                   mosi_q, xv_q};
endmodule

// ===== hdl/sdsr_checker.sv =====
module sdsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	import sdsr_pkg::*;

	// a pending result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// requests flow while the output register is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request refused with empty output");

	// a finished request releases the card with an idle byte
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[O_DONE] |->
		m_tdata[O_XFER] && !m_tdata[O_CS] && m_tdata[O_MOSI +: 8] == BYTE_IDLE)
		else $error("done without release exchange");

	// no exchange means no chip select, no byte and no done
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[O_XFER] |->
		!m_tdata[O_CS] && m_tdata[O_MOSI +: 8] == 8'd0 && !m_tdata[O_DONE] && !m_tdata[O_STATUS])
		else $error("stray exchange fields");
endmodule

bind sd_spi_init_and_sector_read_top sdsr_checker u_sdsr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
